[hdl/crfd_pkg.sv]
package crfd_pkg;

    localparam int MAX_ARGS = 32;
    localparam int ADDR_W   = $clog2(MAX_ARGS);
    localparam int CNT_W    = $clog2(MAX_ARGS + 1);
    localparam int POS_W    = $clog2(MAX_ARGS + 4);

    localparam logic [7:0] ACK_STATUS_OK = 8'h00;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_STATUS = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ARGS   = POS_W'(3);

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_CHECKSUM = 2'd1,
        VERDICT_STATUS   = 2'd2,
        VERDICT_LENGTH   = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_item;

    typedef struct packed {
        logic [7:0] arg_byte;
        logic       arg_valid;
        logic       last;
        t_verdict   verdict;
        logic [7:0] status_byte;
    } t_result;

endpackage

[hdl/checked_reply_frame_deframer.sv]
// Reply frame deframer: command, status, length, arguments, 8-bit sum checksum.
// Input channel: present a byte on i_item with start high; it is taken at the
// rising edge where start is high and busy is low. Bytes of a frame normally
// go in one per cycle, since busy stays low while the frame is gathered.
// Argument bytes are stored in a 32-entry buffer with one write and one
// registered read port.
// Results appear on o_result for one cycle each, flagged by o_strobe. An error
// or empty frame gives one result, in the cycle after the byte that causes it.
// A good frame with N arguments replays the buffer through the single read
// port, one word per cycle: busy goes high after the checksum byte and stays
// high while the N reads are issued, the N words come out through the
// registered read port, and the last one is flagged.
// The receiver cannot stall: every strobed word is taken as it appears.
// Reset (synchronous, i_rst_n low) drops any frame in progress, stops any
// replay and waits for a byte with frame_start set. Buffer contents are not
// cleared; only entries written in the current frame are ever read back.
module checked_reply_frame_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  crfd_pkg::t_item    i_item,
    output logic               o_strobe,
    output crfd_pkg::t_result  o_result
);

    typedef enum logic {
        S_RECV,
        S_REPLAY
    } t_state;

    t_state r_state, n_state;

    logic                          r_active, n_active;
    logic [crfd_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [7:0]                    r_sum, n_sum;
    logic [7:0]                    r_len, n_len;
    logic [7:0]                    r_status_held, n_status_held;
    logic [crfd_pkg::ADDR_W-1:0]   r_rd_idx, n_rd_idx;
    logic [crfd_pkg::CNT_W-1:0]    r_count, n_count;

    logic                          r_strobe, n_strobe;
    logic                          r_from_mem, n_from_mem;
    logic                          r_last, n_last;
    crfd_pkg::t_verdict            r_verdict, n_verdict;

    logic [7:0] r_mem [crfd_pkg::MAX_ARGS];
    logic [7:0] r_rd_data;

    logic                          accept;
    logic [7:0]                    sum_add;
    logic [crfd_pkg::POS_W-1:0]    arg_idx;
    logic                          arg_byte_in;
    logic                          wr_en;
    logic                          replay_last;

    assign accept      = start && (r_state == S_RECV);
    assign sum_add     = r_sum + i_item.rx_byte;
    assign arg_idx     = r_pos - crfd_pkg::POS_ARGS;
    assign arg_byte_in = 8'(arg_idx) < r_len;
    assign replay_last = (crfd_pkg::CNT_W'(r_rd_idx) + crfd_pkg::CNT_W'(1)) == r_count;

    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_pos         = r_pos;
        n_sum         = r_sum;
        n_len         = r_len;
        n_status_held = r_status_held;
        n_rd_idx      = r_rd_idx;
        n_count       = r_count;
        n_strobe      = 1'b0;
        n_from_mem    = 1'b0;
        n_last        = 1'b1;
        n_verdict     = crfd_pkg::VERDICT_OK;
        wr_en         = 1'b0;

        case (r_state)
            S_RECV: begin
                if (accept) begin
                    if (i_item.frame_start) begin
                        n_active      = 1'b1;
                        n_sum         = i_item.rx_byte;
                        n_len         = 8'h00;
                        n_status_held = 8'h00;
                        n_pos         = crfd_pkg::POS_STATUS;
                    end else if (r_active) begin
                        if (r_pos == crfd_pkg::POS_STATUS) begin
                            n_status_held = i_item.rx_byte;
                            n_sum         = sum_add;
                            n_pos         = crfd_pkg::POS_LENGTH;
                        end else if (r_pos == crfd_pkg::POS_LENGTH) begin
                            n_len = i_item.rx_byte;
                            n_sum = sum_add;
                            n_pos = crfd_pkg::POS_ARGS;
                            if (i_item.rx_byte > 8'(crfd_pkg::MAX_ARGS)) begin
                                n_active  = 1'b0;
                                n_strobe  = 1'b1;
                                n_verdict = crfd_pkg::VERDICT_LENGTH;
                            end
                        end else if (arg_byte_in) begin
                            wr_en = 1'b1;
                            n_sum = sum_add;
                            n_pos = r_pos + crfd_pkg::POS_W'(1);
                        end else begin
                            // checksum byte
                            n_active = 1'b0;
                            if (i_item.rx_byte != r_sum) begin
                                n_strobe  = 1'b1;
                                n_verdict = crfd_pkg::VERDICT_CHECKSUM;
                            end else if (r_status_held != crfd_pkg::ACK_STATUS_OK) begin
                                n_strobe  = 1'b1;
                                n_verdict = crfd_pkg::VERDICT_STATUS;
                            end else if (r_len == 8'h00) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state  = S_REPLAY;
                                n_rd_idx = '0;
                                n_count  = crfd_pkg::CNT_W'(r_len);
                            end
                        end
                    end
                end
            end
            S_REPLAY: begin
                // read issued now, word shows up next cycle
                n_strobe   = 1'b1;
                n_from_mem = 1'b1;
                n_last     = replay_last;
                n_rd_idx   = r_rd_idx + crfd_pkg::ADDR_W'(1);
                if (replay_last) begin
                    n_state = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RECV;
            r_active      <= 1'b0;
            r_pos         <= '0;
            r_sum         <= 8'h00;
            r_len         <= 8'h00;
            r_status_held <= 8'h00;
            r_rd_idx      <= '0;
            r_count       <= '0;
            r_strobe      <= 1'b0;
            r_from_mem    <= 1'b0;
            r_last        <= 1'b0;
            r_verdict     <= crfd_pkg::VERDICT_OK;
        end else begin
            r_state       <= n_state;
            r_active      <= n_active;
            r_pos         <= n_pos;
            r_sum         <= n_sum;
            r_len         <= n_len;
            r_status_held <= n_status_held;
            r_rd_idx      <= n_rd_idx;
            r_count       <= n_count;
            r_strobe      <= n_strobe;
            r_from_mem    <= n_from_mem;
            r_last        <= n_last;
            r_verdict     <= n_verdict;
        end
    end

    // argument buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[arg_idx[crfd_pkg::ADDR_W-1:0]] <= i_item.rx_byte;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    assign busy                 = (r_state == S_REPLAY);
    assign o_strobe             = r_strobe;
    assign o_result.arg_byte    = r_from_mem ? r_rd_data : 8'h00;
    assign o_result.arg_valid   = r_from_mem;
    assign o_result.last        = r_last;
    assign o_result.verdict     = r_verdict;
    assign o_result.status_byte = r_status_held;

endmodule

[tb/sv/checked_reply_frame_deframer_tb.sv]
`timescale 1ns / 100ps

module checked_reply_frame_deframer_tb;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_STATUS,
        FR_TOO_LONG,
        FR_CUT,
        FR_NOISE
    } t_frame_kind;

    typedef struct {
        crfd_pkg::t_item rx;
        bit              wait_idle;
    } t_pending;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    crfd_pkg::t_item   i_item;
    logic              o_strobe;
    crfd_pkg::t_result o_result;

    t_pending          pending_bytes[$];
    crfd_pkg::t_result expected_words[$];
    int        mismatches = 0;
    int        frame_bytes = 0;

    // predictor state
    int          rx_pos = 0;
    logic [7:0]  rx_sum = 8'd0;
    logic [7:0]  rx_len = 8'd0;
    logic [7:0]  rx_status = 8'd0;
    bit          rx_active = 1'b0;
    logic [7:0]  arg_store [crfd_pkg::MAX_ARGS];

    // sender pacing
    int burst_left = 8;
    int gap_left = 0;

    checked_reply_frame_deframer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void expect_word(input logic [7:0] arg, input logic valid,
                                        input logic last,
                                        input crfd_pkg::t_verdict verdict);
        crfd_pkg::t_result w;
        w.arg_byte    = arg;
        w.arg_valid   = valid;
        w.last        = last;
        w.verdict     = verdict;
        w.status_byte = rx_status;
        expected_words.push_back(w);
    endfunction

    function automatic void deframe_byte(input crfd_pkg::t_item rx);
        logic [7:0] b;
        int idx;
        b = rx.rx_byte;
        if (rx.frame_start) begin
            rx_active = 1'b1;
            rx_sum    = b;
            rx_len    = 8'd0;
            rx_status = 8'd0;
            rx_pos    = 1;
            return;
        end
        if (!rx_active)
            return;
        if (rx_pos == 1) begin
            rx_status = b;
            rx_sum    = rx_sum + b;
            rx_pos    = 2;
            return;
        end
        if (rx_pos == 2) begin
            rx_len = b;
            rx_sum = rx_sum + b;
            rx_pos = 3;
            if (b > crfd_pkg::MAX_ARGS) begin
                rx_active = 1'b0;
                expect_word(8'd0, 1'b0, 1'b1, crfd_pkg::VERDICT_LENGTH);
            end
            return;
        end
        idx = rx_pos - 3;
        if (idx < rx_len) begin
            arg_store[idx] = b;
            rx_sum = rx_sum + b;
            rx_pos++;
            return;
        end
        // checksum byte closes the frame
        rx_active = 1'b0;
        if (b != rx_sum)
            expect_word(8'd0, 1'b0, 1'b1, crfd_pkg::VERDICT_CHECKSUM);
        else if (rx_status != crfd_pkg::ACK_STATUS_OK)
            expect_word(8'd0, 1'b0, 1'b1, crfd_pkg::VERDICT_STATUS);
        else if (rx_len == 0)
            expect_word(8'd0, 1'b0, 1'b1, crfd_pkg::VERDICT_OK);
        else
            for (int i = 0; i < rx_len; i++)
                expect_word(arg_store[i], 1'b1, (i + 1 == rx_len), crfd_pkg::VERDICT_OK);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fs, input bit hold);
        t_pending p;
        p.rx.rx_byte     = b;
        p.rx.frame_start = fs;
        p.wait_idle      = hold;
        pending_bytes.push_back(p);
    endtask

    task automatic queue_frame(input t_frame_kind kind, input bit hold);
        logic [7:0] fr[$];
        logic [7:0] sum;
        logic [7:0] st;
        logic [7:0] len;
        int r;
        int keep;
        if (kind == FR_NOISE) begin
            // stray bytes, no frame start
            repeat ($urandom_range(1, 4))
                push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            return;
        end
        st = 8'd0;
        if (kind == FR_BAD_STATUS || (kind == FR_BAD_SUM && $urandom_range(0, 1)))
            st = 8'($urandom_range(1, 255));
        if (kind == FR_TOO_LONG) begin
            len = 8'($urandom_range(crfd_pkg::MAX_ARGS + 1, 255));
        end else begin
            r = $urandom_range(0, 9);
            if (r < 7)
                len = 8'($urandom_range(0, 6));
            else if (r < 9)
                len = 8'($urandom_range(7, crfd_pkg::MAX_ARGS - 1));
            else
                len = 8'(crfd_pkg::MAX_ARGS);
        end
        fr.push_back(8'($urandom_range(0, 255)));
        fr.push_back(st);
        fr.push_back(len);
        if (kind == FR_TOO_LONG) begin
            // trailing bytes are ignored once the length is refused
            repeat ($urandom_range(0, 3))
                fr.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (len)
                fr.push_back(8'($urandom_range(0, 255)));
            sum = 8'd0;
            foreach (fr[i])
                sum = sum + fr[i];
            if (kind == FR_BAD_SUM)
                sum = sum ^ 8'($urandom_range(1, 255));
            fr.push_back(sum);
        end
        keep = fr.size();
        if (kind == FR_CUT)
            keep = $urandom_range(1, fr.size() - 1);
        for (int i = 0; i < keep; i++) begin
            push_byte(fr[i], (i == 0), hold && (i == 0));
            frame_bytes++;
        end
    endtask

    task automatic queue_directed;
        // empty good frame
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        // two arguments at the byte extremes, sent from idle
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        // bad sum and bad status together: sum wins
        push_byte(8'h12, 1'b1, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        // nonzero status, sum right
        push_byte(8'h01, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        // one past the buffer size, then a byte outside any frame
        push_byte(8'h55, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'd33, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b0, 1'b0);
        // largest length byte
        push_byte(8'hAA, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            if (start && !busy) begin
                deframe_byte(i_item);
                void'(pending_bytes.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].wait_idle && expected_words.size() > 0)) begin
                start  <= 1'b1;
                i_item <= pending_bytes[0].rx;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        crfd_pkg::t_result w;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with none expected");
            end else begin
                w = expected_words.pop_front();
                if (o_result.arg_byte !== w.arg_byte)
                    report_mismatch($sformatf("arg_byte %h, want %h",
                                              o_result.arg_byte, w.arg_byte));
                if (o_result.arg_valid !== w.arg_valid)
                    report_mismatch($sformatf("arg_valid %b, want %b",
                                              o_result.arg_valid, w.arg_valid));
                if (o_result.last !== w.last)
                    report_mismatch($sformatf("last %b, want %b", o_result.last, w.last));
                if (o_result.verdict !== w.verdict)
                    report_mismatch($sformatf("verdict %0d, want %0d",
                                              o_result.verdict, w.verdict));
                if (o_result.status_byte !== w.status_byte)
                    report_mismatch($sformatf("status_byte %h, want %h",
                                              o_result.status_byte, w.status_byte));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int r;
        bit first_random;
        i_rst_n      = 1'b0;
        first_random = 1'b1;

        queue_directed();
        while (frame_bytes < 250) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_frame(FR_GOOD, first_random || $urandom_range(0, 19) == 0);
            else if (r < 75)
                queue_frame(FR_BAD_SUM, 1'b0);
            else if (r < 85)
                queue_frame(FR_BAD_STATUS, 1'b0);
            else if (r < 90)
                queue_frame(FR_TOO_LONG, 1'b0);
            else if (r < 95)
                queue_frame(FR_CUT, 1'b0);
            else
                queue_frame(FR_NOISE, 1'b0);
            first_random = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_words.size() != 0)
            @(posedge i_clk);
        // allow for a late stray word after the last replay
        repeat (40) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
